@@ design/gh_pkg.sv @@
// ============================================================================
// gh_pkg: shared types and helpers for the GHASH accumulator
// Widths of the 128-bit field elements, the configuration register map and
// the bit-reversal helper that maps between GCM bit order and polynomial order.
// ============================================================================
`default_nettype none

package gh_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned BLK_W   = 2 * HALF_W;
    localparam int unsigned NBYTES  = BLK_W / 8;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned S_TDATA_W = 136;

    typedef logic [BLK_W-1:0]  t_blk;
    typedef logic [HALF_W-1:0] t_half;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Configuration register map.
    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_reg;

    // GCM numbers bit 0 as the MSB; the polynomial form wants it as the LSB.
    function automatic t_blk rev_blk(input t_blk v);
        t_blk r;
        for (int i = 0; i < BLK_W; i++) begin
            r[i] = v[BLK_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/gh_gfmul.sv @@
// ============================================================================
// gh_gfmul: combinational GF(2^128) multiplier in GCM bit order
// Carryless 128x128 product followed by a two-fold reduction modulo
// x^128 + x^7 + x^2 + x + 1.
// ============================================================================
`default_nettype none

module gh_gfmul (
    input  wire gh_pkg::t_blk i_x,
    input  wire gh_pkg::t_blk i_y,
    output gh_pkg::t_blk      o_z
);
    import gh_pkg::*;

    t_blk          a;
    t_blk          b;
    logic [254:0]  prod;
    logic [126:0]  hi;
    logic [133:0]  fold1;
    logic [5:0]    spill;
    t_blk          z;

    // Carryless product: XOR of the shifted rows selected by the bits of a.
    always_comb begin
        a    = rev_blk(i_x);
        b    = rev_blk(i_y);
        prod = '0;
        for (int i = 0; i < BLK_W; i++) begin
            prod = prod ^ (({127'b0, b} << i) & {255{a[i]}});
        end
    end

    // Reduction: x^128 folds back as x^7 + x^2 + x + 1, twice.
    always_comb begin
        hi    = prod[254:128];
        fold1 = {6'b0, prod[127:0]} ^ {7'b0, hi} ^ {6'b0, hi, 1'b0}
              ^ {5'b0, hi, 2'b0} ^ {hi, 7'b0};
        spill = fold1[133:128];
        z     = fold1[127:0] ^ {122'b0, spill} ^ {121'b0, spill, 1'b0}
              ^ {120'b0, spill, 2'b0} ^ {115'b0, spill, 7'b0};
    end

    assign o_z = rev_blk(z);

endmodule

`default_nettype wire

@@ design/ghash_accumulator.sv @@
// ============================================================================
// ghash_accumulator: GCM GHASH over GF(2^128)
// Absorbs one 16-byte block per item into the running hash and emits the
// tag on the item marked last.
// ============================================================================
// The block takes one item per clock cycle while no last item waits. Each
// accepted item sits in an input register. From there one full GF(2^128)
// multiply by the key and its reduction update the accumulator, and on a
// last item the tag is loaded into the output register, from which it is
// presented. That multiply loop sets the rate. A last item waits in the
// input register only while an earlier tag is still held in the output
// register and is not taken in the same cycle; new items wait behind it for
// that time. Write the key through the configuration port while no message
// is in flight.
`default_nettype none

module ghash_accumulator (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // Configuration write port.
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_addr,
    input  wire gh_pkg::t_half          i_cfg_wdata,
    // Input items.
    input  wire                         i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: block_high[63:0], block_low[127:64], valid_bytes[132:128], zero pad
    input  wire [gh_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tlast: last_block
    input  wire                         i_s_axis_tlast,
    // Result items.
    output logic                        o_m_axis_tvalid,
    input  wire                         i_m_axis_tready,
    // tdata: tag_high[63:0], tag_low[127:64]
    output gh_pkg::t_blk                o_m_axis_tdata
);
    import gh_pkg::*;

    t_half r_key_high;
    t_half r_key_low;
    t_blk  r_acc;
    logic  r_in_valid;
    logic  r_in_last;
    t_blk  r_in_blk;
    t_cnt  r_in_cnt;
    logic  r_out_valid;
    t_blk  r_out_tag;

    logic  w_retire;
    logic  w_cnt_zero;
    t_blk  w_mask;
    t_blk  w_sum;
    t_blk  w_prod;
    t_blk  n_acc;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A last item leaves only when the output register is free or draining.
    assign w_retire        = r_in_valid & (~r_in_last | ~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | w_retire;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_blk  <= {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
            r_in_cnt  <= i_s_axis_tdata[132:128];
            r_in_last <= i_s_axis_tlast;
        end
    end

    // Keep the leading valid bytes; counts of sixteen and above keep all.
    always_comb begin
        w_cnt_zero = (r_in_cnt == '0);
        for (int b = 0; b < NBYTES; b++) begin
            w_mask[BLK_W-1-8*b -: 8] = {8{r_in_cnt[CNT_W-1] | (4'(b) < r_in_cnt[3:0])}};
        end
        w_sum = r_acc ^ (r_in_blk & w_mask);
    end

    gh_gfmul u_gfmul (
        .i_x (w_sum),
        .i_y ({r_key_high, r_key_low}),
        .o_z (w_prod)
    );

    assign n_acc = w_cnt_zero ? r_acc : w_prod;

    // Accumulator: cleared after the tag is taken from it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_retire) begin
            r_acc <= r_in_last ? '0 : n_acc;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_retire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_retire && r_in_last) begin
            r_out_tag <= n_acc;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_tag[HALF_W-1:0], r_out_tag[BLK_W-1:HALF_W]};

    // The accumulator starts from zero after every tag.
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_retire && r_in_last) |=> (r_acc == '0))
        else $error("accumulator not cleared after tag");

    // A retired last item always produces a pending tag.
    a_tag_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_retire && r_in_last) |=> r_out_valid)
        else $error("tag missing after last item");

    // An item with no valid bytes that is not last leaves the hash unchanged.
    a_zero_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_retire && w_cnt_zero && !r_in_last) |=> $stable(r_acc))
        else $error("empty item changed the accumulator");

    // A waiting item stays in the input register.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_retire) |=> (r_in_valid && $stable(r_in_blk)))
        else $error("stalled item lost");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking testbench for the GHASH accumulator
// Streams 16-byte blocks into the block under test, keeps a bit-accurate
// GF(2^128) hash of its own with a private copy of the key, and compares
// each emitted tag with the oldest predicted one. Directed messages cover
// empty and partial blocks, saturated byte counts and extreme keys. Random
// phases then follow with varied keys and random gaps and stalls.
// ============================================================================
module tb_top;

    import gh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One input item as seen by the testbench.
    typedef struct {
        t_half blk_hi;
        t_half blk_lo;
        t_cnt  nbytes;
        logic  last;
    } t_block_item;

    // Clock, reset and DUT-facing signals; those the testbench drives are known from time zero.
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    t_cfg_reg             cfg_addr = CFG_KEY_HIGH;
    t_half                cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    t_blk                 m_tdata;

    // Predictor state and scoreboard.
    t_half         key_hi_copy = '0;
    t_half         key_lo_copy = '0;
    t_blk          hash_acc = '0;
    t_blk          expected_tags[$];
    t_block_item   block_queue[$];
    t_block_item   item_on_bus;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int            send_gap_left = 0;
    int            recv_stall_left = 0;
    logic          send_gaps = 1'b1;
    logic          recv_stalls = 1'b1;

    always #10 i_clk = ~i_clk;

    ghash_accumulator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // Carry-less multiply in GCM bit order, reduced by x^128+x^7+x^2+x+1.
    function automatic t_blk gf128_mult(input t_blk x, input t_blk y);
        t_blk prod;
        t_blk v;
        logic lsb;
        prod = '0;
        v = y;
        for (int i = 0; i < BLK_W; i++) begin
            if (x[BLK_W-1-i]) begin
                prod ^= v;
            end
            lsb = v[0];
            v = v >> 1;
            if (lsb) begin
                v[BLK_W-1 -: 8] ^= 8'hE1;
            end
        end
        return prod;
    endfunction

    // Absorb one accepted block; a last block yields a predicted tag.
    function automatic void ghash_absorb(input t_block_item it);
        int unsigned n;
        t_blk        mask;
        n = (it.nbytes > NBYTES) ? NBYTES : it.nbytes;
        if (n != 0) begin
            mask = {BLK_W{1'b1}} << (BLK_W - 8 * n);
            hash_acc = gf128_mult(hash_acc ^ ({it.blk_hi, it.blk_lo} & mask),
                                  {key_hi_copy, key_lo_copy});
        end
        if (it.last) begin
            expected_tags.push_back(hash_acc);
            hash_acc = '0;
        end
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int draw_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_half rand_half();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input t_half exp_v, input t_half got_v);
        $display("mismatch %s: expected %h, got %h (cycle %0d)", what, exp_v, got_v,
                 cycle_count);
        mismatch_count++;
    endtask

    task automatic push_block(input t_half hi, input t_half lo, input int unsigned n,
                              input logic last);
        t_block_item it;
        it.blk_hi = hi;
        it.blk_lo = lo;
        it.nbytes = t_cnt'(n);
        it.last = last;
        block_queue.push_back(it);
    endtask

    // Register write; the block is idle whenever this is called.
    task automatic cfg_write(input t_cfg_reg idx, input t_half value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        if (idx == CFG_KEY_HIGH) begin
            key_hi_copy = value;
        end else begin
            key_lo_copy = value;
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold off until every queued item is taken and every tag has arrived.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (block_queue.size() != 0 || s_tvalid || expected_tags.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Driver: presents queued items and feeds the predictor on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tlast <= 1'b0;
            s_tdata <= '0;
            send_gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                ghash_absorb(item_on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap_left > 0) begin
                    send_gap_left--;
                    s_tvalid <= 1'b0;
                end else if (block_queue.size() != 0) begin
                    item_on_bus = block_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tlast <= item_on_bus.last;
                    s_tdata <= {3'b000, item_on_bus.nbytes, item_on_bus.blk_lo,
                                item_on_bus.blk_hi};
                    send_gap_left = send_gaps ? draw_idle() : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted tag and applies random back-pressure.
    always @(posedge i_clk) begin
        t_blk exp_tag;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_tags.size() == 0) begin
                    report_mismatch("unexpected tag_high", '0, m_tdata[63:0]);
                end else begin
                    exp_tag = expected_tags.pop_front();
                    if (m_tdata[63:0] !== exp_tag[127:64]) begin
                        report_mismatch("tag_high", exp_tag[127:64], m_tdata[63:0]);
                    end
                    if (m_tdata[127:64] !== exp_tag[63:0]) begin
                        report_mismatch("tag_low", exp_tag[63:0], m_tdata[127:64]);
                    end
                end
            end
            if (recv_stall_left > 0) begin
                recv_stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_stall_left = recv_stalls ? draw_idle() : 0;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        int unsigned pushed;
        int unsigned msg_len;
        int unsigned r;
        int unsigned n;
        t_half       hi;
        t_half       lo;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Key still zero after reset: every tag is zero, empty message too.
        push_block(rand_half(), rand_half(), 16, 1'b1);
        push_block('0, '0, 0, 1'b1);
        wait_idle();

        // Multiplicative identity as key: a single full block comes back as is.
        cfg_write(CFG_KEY_HIGH, 64'h8000_0000_0000_0000);
        cfg_write(CFG_KEY_LOW, '0);
        push_block('1, '1, 16, 1'b1);
        push_block(rand_half(), rand_half(), 5, 1'b0);
        push_block(rand_half(), rand_half(), 13, 1'b1);
        push_block(rand_half(), rand_half(), 31, 1'b1);
        push_block(rand_half(), rand_half(), 8, 1'b1);
        wait_idle();

        // All-ones key; zero counts, saturated counts and partial blocks.
        cfg_write(CFG_KEY_HIGH, '1);
        cfg_write(CFG_KEY_LOW, '1);
        push_block('1, '1, 16, 1'b0);
        push_block(rand_half(), rand_half(), 0, 1'b0);
        push_block(rand_half(), rand_half(), 17, 1'b0);
        push_block(rand_half(), rand_half(), 0, 1'b1);
        push_block('0, '0, 0, 1'b1);
        push_block('0, '0, 16, 1'b1);
        push_block(rand_half(), rand_half(), 1, 1'b1);
        push_block(rand_half(), rand_half(), 9, 1'b0);
        push_block(rand_half(), rand_half(), 15, 1'b1);
        push_block(rand_half(), rand_half(), 24, 1'b1);

        // Key change in the middle of a message.
        push_block(rand_half(), rand_half(), 16, 1'b0);
        wait_idle();
        cfg_write(CFG_KEY_LOW, rand_half());
        push_block(rand_half(), rand_half(), 16, 1'b1);
        wait_idle();

        // Random phases, each with its own key and idling mix.
        for (int p = 0; p < 10; p++) begin
            send_gaps = (p % 3) != 0;
            recv_stalls = (p % 2) == 0;
            case (p % 4)
                0: begin
                    cfg_write(CFG_KEY_HIGH, rand_half());
                    cfg_write(CFG_KEY_LOW, rand_half());
                end
                1: cfg_write(CFG_KEY_HIGH, rand_half());
                2: cfg_write(CFG_KEY_LOW, rand_half());
                default: begin
                    cfg_write(CFG_KEY_HIGH, '1);
                    cfg_write(CFG_KEY_LOW, rand_half());
                end
            endcase
            if (p == 9) begin
                cfg_write(CFG_KEY_HIGH, '0);
                cfg_write(CFG_KEY_LOW, '0);
            end
            pushed = 0;
            while (pushed < 50) begin
                msg_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 12);
                for (int b = 0; b < msg_len; b++) begin
                    r = $urandom_range(0, 99);
                    if (r < 70) begin
                        n = 16;
                    end else if (r < 82) begin
                        n = $urandom_range(1, 15);
                    end else if (r < 90) begin
                        n = 0;
                    end else begin
                        n = $urandom_range(17, 31);
                    end
                    r = $urandom_range(0, 99);
                    if (r < 6) begin
                        hi = '0;
                        lo = '0;
                    end else if (r < 12) begin
                        hi = '1;
                        lo = '1;
                    end else begin
                        hi = rand_half();
                        lo = rand_half();
                    end
                    // Some phases stop with a message left open across the key write.
                    push_block(hi, lo, n,
                               (b == msg_len - 1) && !((p % 3 == 1) && (pushed + b >= 49)));
                end
                pushed += msg_len;
            end
            wait_idle();
        end

        // Close any open message so its tag is checked too.
        push_block(rand_half(), rand_half(), 16, 1'b1);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
